@@ rtl/core/pwmlo_pkg.sv @@
// Shared constants, codes and types of the position weight matrix log-odds converter.
package pwmlo_pkg;

    localparam int MAX_ROWS    = 16;
    localparam int MAX_LENGTH  = 64;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_LENGTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ROW_W       = 4;
    localparam int COL_W       = 6;
    localparam int LEN_W       = 7;
    localparam int COUNT_W     = 16;
    localparam int RSUM_W      = 22;
    localparam int TOTAL_W     = 26;
    localparam int WEIGHT_W    = 22;
    localparam int STATUS_W    = 2;

    // ln 2 in Q32.
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_CONVERT = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOTAL_0   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ROW_0     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUT_RANGE = 2'd3;

    localparam logic CFG_DINUC  = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    // Operands of one log-odds evaluation.
    typedef struct packed {
        logic               dinuc;
        logic [LEN_W-1:0]   len;
        logic [COUNT_W-1:0] count;
        logic [RSUM_W-1:0]  rowsum;
        logic [TOTAL_W-1:0] total;
    } pwmlo_args_t;

endpackage

@@ rtl/core/pwmlo_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pwmlo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/pwmlo_log_core.sv @@
// Sequenced log-odds datapath: one shared adder and one shared multiplier.
module pwmlo_log_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  pwmlo_pkg::pwmlo_args_t            args,
    output logic                              done,
    output logic [pwmlo_pkg::WEIGHT_W-1:0]    weight
);
    import pwmlo_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE, C_MULA, C_DIVN, C_MULB, C_NORMA, C_NORMB,
        C_PRE, C_LDIV, C_SQR, C_SQRUPD, C_SCALE, C_ROUND
    } cstate_t;

    cstate_t            state_reg;
    pwmlo_args_t        args_reg;
    logic [63:0]        acc_reg, x_reg, y_reg, a_reg, b_reg, prod_reg;
    logic [31:0]        z_reg;
    logic [19:0]        frac_reg;
    logic signed [7:0]  e_reg;
    logic [5:0]         step_reg;
    logic               neg_reg;
    logic               done_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    // Shared adder / subtractor. With subtraction the carry means a >= b.
    logic [63:0] add_a, add_b, add_sum;
    logic        add_sub, add_cout;
    // Shared multiplier.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    logic [19:0] mcand_a;
    logic [26:0] n_plus1;
    logic [30:0] mcand_b;
    logic [63:0] acc_mul, y_div;
    logic [31:0] zz;
    logic [27:0] l2, mag;
    logic [63:0] rnd;
    logic [23:0] r_full;
    logic [21:0] r_sat;

    always_comb
    begin
        add_a   = acc_reg;
        add_b   = 64'd0;
        add_sub = 1'b0;
        unique case (state_reg)
            C_MULA, C_MULB:
            begin
                add_b = x_reg;
            end
            C_DIVN:
            begin
                add_a   = {acc_reg[62:0], x_reg[TOTAL_W-1]};
                add_b   = 64'(args_reg.len);
                add_sub = 1'b1;
            end
            C_PRE:
            begin
                add_a   = a_reg;
                add_b   = b_reg;
                add_sub = 1'b1;
            end
            C_LDIV:
            begin
                add_a   = {acc_reg[62:0], 1'b0};
                add_b   = b_reg;
                add_sub = 1'b1;
            end
            default:
            begin
                add_a = acc_reg;
            end
        endcase
        {add_cout, add_sum} = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                              + 65'(add_sub);
    end

    always_comb
    begin
        l2  = {e_reg, 20'd0} + {8'd0, frac_reg};
        mag = l2[27] ? (28'd0 - l2) : l2;
        if (state_reg == C_SCALE)
        begin
            mul_a = {5'd0, mag[26:0]};
            mul_b = LN2_Q32;
        end
        else
        begin
            mul_a = z_reg;
            mul_b = z_reg;
        end
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    always_comb
    begin
        mcand_a = args.dinuc ? {args.count, 4'b0001} : {2'b00, args.count, 2'b01};
        y_div   = {y_reg[62:0], add_cout};
        n_plus1 = 27'(y_div[TOTAL_W-1:0]) + 27'd1;
        mcand_b = args_reg.dinuc ? {n_plus1, 4'b0000} : {2'b00, n_plus1, 2'b00};
        acc_mul = y_reg[0] ? add_sum : acc_reg;
        zz      = prod_reg[61:30];
        rnd     = prod_reg + (64'd1 << 35);
        r_full  = rnd[59:36];
        r_sat   = (r_full > 24'd2097152) ? 22'h200000 : r_full[21:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        args_reg  <= args;
                        x_reg     <= 64'(mcand_a);
                        y_reg     <= 64'(args.total);
                        acc_reg   <= 64'd0;
                        step_reg  <= 6'(TOTAL_W - 1);
                        state_reg <= C_MULA;
                    end
                end
                // A = (count * size + 1) * total, shift and add.
                C_MULA:
                begin
                    acc_reg  <= acc_mul;
                    x_reg    <= {x_reg[62:0], 1'b0};
                    y_reg    <= {1'b0, y_reg[63:1]};
                    step_reg <= step_reg - 6'd1;
                    if (step_reg == 6'd0)
                    begin
                        a_reg     <= acc_mul;
                        acc_reg   <= 64'd0;
                        x_reg     <= 64'(args_reg.total);
                        y_reg     <= 64'd0;
                        step_reg  <= 6'(TOTAL_W - 1);
                        state_reg <= C_DIVN;
                    end
                end
                // N = total / length, restoring division.
                C_DIVN:
                begin
                    acc_reg  <= add_cout ? add_sum : add_a;
                    y_reg    <= y_div;
                    x_reg    <= {x_reg[62:0], 1'b0};
                    step_reg <= step_reg - 6'd1;
                    if (step_reg == 6'd0)
                    begin
                        acc_reg   <= 64'd0;
                        x_reg     <= 64'(mcand_b);
                        y_reg     <= 64'(args_reg.rowsum);
                        step_reg  <= 6'(RSUM_W - 1);
                        state_reg <= C_MULB;
                    end
                end
                // B = size * (N + 1) * rowsum.
                C_MULB:
                begin
                    acc_reg  <= acc_mul;
                    x_reg    <= {x_reg[62:0], 1'b0};
                    y_reg    <= {1'b0, y_reg[63:1]};
                    step_reg <= step_reg - 6'd1;
                    if (step_reg == 6'd0)
                    begin
                        b_reg     <= acc_mul;
                        e_reg     <= 8'sd0;
                        state_reg <= C_NORMA;
                    end
                end
                // Bring the leading one of each operand to bit 61.
                C_NORMA:
                begin
                    if (a_reg[61])
                    begin
                        state_reg <= C_NORMB;
                    end
                    else if (a_reg[61:58] == 4'd0)
                    begin
                        a_reg <= {a_reg[59:0], 4'd0};
                        e_reg <= e_reg - 8'sd4;
                    end
                    else
                    begin
                        a_reg <= {a_reg[62:0], 1'b0};
                        e_reg <= e_reg - 8'sd1;
                    end
                end
                C_NORMB:
                begin
                    if (b_reg[61])
                    begin
                        state_reg <= C_PRE;
                    end
                    else if (b_reg[61:58] == 4'd0)
                    begin
                        b_reg <= {b_reg[59:0], 4'd0};
                        e_reg <= e_reg + 8'sd4;
                    end
                    else
                    begin
                        b_reg <= {b_reg[62:0], 1'b0};
                        e_reg <= e_reg + 8'sd1;
                    end
                end
                // The ratio must lie in [1,2); otherwise double A once.
                C_PRE:
                begin
                    if (add_cout)
                    begin
                        acc_reg   <= add_sum;
                        y_reg     <= 64'd1;
                        step_reg  <= 6'd29;
                        state_reg <= C_LDIV;
                    end
                    else
                    begin
                        a_reg <= {a_reg[62:0], 1'b0};
                        e_reg <= e_reg - 8'sd1;
                    end
                end
                C_LDIV:
                begin
                    acc_reg  <= add_cout ? add_sum : add_a;
                    y_reg    <= y_div;
                    step_reg <= step_reg - 6'd1;
                    if (step_reg == 6'd0)
                    begin
                        z_reg     <= y_div[31:0];
                        frac_reg  <= 20'd0;
                        step_reg  <= 6'd19;
                        state_reg <= C_SQR;
                    end
                end
                C_SQR:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= C_SQRUPD;
                end
                // One fraction bit of log2 per squaring.
                C_SQRUPD:
                begin
                    frac_reg <= {frac_reg[18:0], zz[31]};
                    z_reg    <= zz[31] ? {1'b0, zz[31:1]} : zz;
                    step_reg <= step_reg - 6'd1;
                    state_reg <= (step_reg == 6'd0) ? C_SCALE : C_SQR;
                end
                C_SCALE:
                begin
                    prod_reg  <= mul_p;
                    neg_reg   <= l2[27];
                    state_reg <= C_ROUND;
                end
                C_ROUND:
                begin
                    if (neg_reg)
                    begin
                        weight_reg <= 22'd0 - r_sat;
                    end
                    else
                    begin
                        weight_reg <= (r_sat == 22'h200000) ? 22'h1FFFFF : r_sat;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign weight = weight_reg;

endmodule

@@ rtl/core/pwm_log_odds_converter.sv @@
// Top level of the position weight matrix log-odds converter.
// Input items arrive on the s_ stream; s_tuser carries the operation (write count,
// convert entry, clear store) and s_tdata the row, column and count. Only a convert
// produces a transaction on the m_ stream: the weight in signed Q5.16 and a status.
// The cfg channel writes the symbol mode (index 0) and the motif length (index 1);
// every configuration write also clears the count store and the sums.
// cfg_ready is high only while the block is idle, and a configuration transaction
// takes precedence over an s_ transaction offered in the same cycle.
// A write reads the old count, then updates the count and the sums. A convert with an
// error status yields a zero weight without the log unit; otherwise it runs through
// the shared adder and multiplier of the log unit: the products and the mean,
// normalizing, the long division and the squarings.
// The block takes no item while it works on one.
// After reset, and after a clear item or a configuration write, a clearing pass
// zeroes all 1024 count memory entries one entry per cycle; s_tready stays low then.
// The result sits in an output register, so the next item may be taken while it
// waits; a later convert finishes only once that register has been emptied.
module pwm_log_odds_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // row[3:0], column[9:4], count[25:10], zeros
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // weight[21:0], status[23:22]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);
    import pwmlo_pkg::*;

    typedef enum logic [2:0] {
        T_CLEAR, T_IDLE, T_LOOK, T_WUPD, T_START, T_CALC, T_HOLD
    } tstate_t;

    tstate_t             state_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic                dinuc_reg;
    logic [LEN_W-1:0]    motif_len_reg;
    logic [1:0]          op_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_reg;
    logic [COUNT_W-1:0]  cnt_reg;
    logic [RSUM_W-1:0]   row_sums_reg [MAX_ROWS];
    logic [TOTAL_W-1:0]  total_reg;
    logic [WEIGHT_W-1:0] res_weight_reg, out_weight_reg;
    logic [STATUS_W-1:0] res_status_reg, out_status_reg;
    logic                m_valid_reg;

    logic [LEN_W-1:0]    len_used;
    logic                in_range;
    logic                any_row_zero;
    logic [STATUS_W-1:0] check_status;
    logic [RSUM_W-1:0]   cur_rowsum;
    logic [COUNT_W-1:0]  ram_rdata;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, item_addr;
    logic [COUNT_W-1:0]  ram_wdata;
    logic                s_acc, cfg_acc, out_free;
    logic                core_start, core_done;
    logic [WEIGHT_W-1:0] core_weight;
    pwmlo_args_t         core_args;

    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = (state_reg == T_IDLE);
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == T_IDLE) && !cfg_valid;
    assign out_free  = !m_valid_reg || m_tready;
    assign item_addr = {row_reg, col_reg};

    always_comb
    begin
        if (motif_len_reg == 7'd0)
        begin
            len_used = 7'd1;
        end
        else if (motif_len_reg > 7'(MAX_LENGTH))
        begin
            len_used = 7'(MAX_LENGTH);
        end
        else
        begin
            len_used = motif_len_reg;
        end
        in_range   = (dinuc_reg || row_reg < 4'd4) && ({1'b0, col_reg} < len_used);
        cur_rowsum = row_sums_reg[row_reg];
        any_row_zero = 1'b0;
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            if ((dinuc_reg || i < 4) && row_sums_reg[i] == '0)
            begin
                any_row_zero = 1'b1;
            end
        end
        priority if (!in_range)
        begin
            check_status = ST_OUT_RANGE;
        end
        else if (total_reg == '0)
        begin
            check_status = ST_TOTAL_0;
        end
        else if (any_row_zero)
        begin
            check_status = ST_ROW_0;
        end
        else
        begin
            check_status = ST_OK;
        end
    end

    assign ram_we    = (state_reg == T_CLEAR) || (state_reg == T_WUPD);
    assign ram_waddr = (state_reg == T_CLEAR) ? clr_cnt_reg : item_addr;
    assign ram_wdata = (state_reg == T_CLEAR) ? '0 : cnt_reg;

    pwmlo_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (item_addr),
        .rdata (ram_rdata)
    );

    assign core_start       = (state_reg == T_START);
    assign core_args.dinuc  = dinuc_reg;
    assign core_args.len    = len_used;
    assign core_args.count  = ram_rdata;
    assign core_args.rowsum = cur_rowsum;
    assign core_args.total  = total_reg;

    pwmlo_log_core u_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (core_start),
        .args   (core_args),
        .done   (core_done),
        .weight (core_weight)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_CLEAR;
            clr_cnt_reg   <= '0;
            dinuc_reg     <= 1'b0;
            motif_len_reg <= 7'd1;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                row_sums_reg[i] <= '0;
            end
        end
        else
        begin
            if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1))
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                T_IDLE:
                begin
                    if (s_acc)
                    begin
                        op_reg  <= s_tuser;
                        row_reg <= s_tdata[3:0];
                        col_reg <= s_tdata[9:4];
                        cnt_reg <= s_tdata[25:10];
                        priority case (s_tuser)
                            OP_CLEAR:
                            begin
                                total_reg   <= '0;
                                clr_cnt_reg <= '0;
                                state_reg   <= T_CLEAR;
                                for (int i = 0; i < MAX_ROWS; i++)
                                begin
                                    row_sums_reg[i] <= '0;
                                end
                            end
                            OP_WRITE, OP_CONVERT:
                            begin
                                state_reg <= T_LOOK;
                            end
                            default:
                            begin
                                state_reg <= T_IDLE;
                            end
                        endcase
                    end
                end
                // The stored count is read during this cycle.
                T_LOOK:
                begin
                    if (op_reg == OP_WRITE)
                    begin
                        state_reg <= in_range ? T_WUPD : T_IDLE;
                    end
                    else if (check_status != ST_OK)
                    begin
                        res_weight_reg <= '0;
                        res_status_reg <= check_status;
                        state_reg      <= T_HOLD;
                    end
                    else
                    begin
                        state_reg <= T_START;
                    end
                end
                T_WUPD:
                begin
                    row_sums_reg[row_reg] <= cur_rowsum - RSUM_W'(ram_rdata)
                                             + RSUM_W'(cnt_reg);
                    total_reg <= total_reg - TOTAL_W'(ram_rdata) + TOTAL_W'(cnt_reg);
                    state_reg <= T_IDLE;
                end
                T_START:
                begin
                    state_reg <= T_CALC;
                end
                T_CALC:
                begin
                    if (core_done)
                    begin
                        res_weight_reg <= core_weight;
                        res_status_reg <= ST_OK;
                        state_reg      <= T_HOLD;
                    end
                end
                T_HOLD:
                begin
                    if (out_free)
                    begin
                        out_weight_reg <= res_weight_reg;
                        out_status_reg <= res_status_reg;
                        m_valid_reg    <= 1'b1;
                        state_reg      <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
            // Any register write empties the matrix.
            if (cfg_acc)
            begin
                if (cfg_index == CFG_DINUC)
                begin
                    dinuc_reg <= cfg_data[0];
                end
                else
                begin
                    motif_len_reg <= cfg_data;
                end
                total_reg   <= '0;
                clr_cnt_reg <= '0;
                state_reg   <= T_CLEAR;
                for (int i = 0; i < MAX_ROWS; i++)
                begin
                    row_sums_reg[i] <= '0;
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_status_reg, out_weight_reg};

    a_core_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        core_done |-> state_reg == T_CALC)
        else $error("log unit finished outside a convert");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_acc |=> (state_reg == T_CLEAR && total_reg == '0 && clr_cnt_reg == '0))
        else $error("configuration write did not restart clearing");

    a_clear_op: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == OP_CLEAR && !cfg_valid)
        |=> (total_reg == '0 && state_reg == T_CLEAR))
        else $error("clear item did not empty the matrix");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the position weight matrix log-odds converter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pwmlo_pkg::*;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [STATUS_W-1:0] status;
    } odds_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [6:0]  cfg_data;

    // Shadow copy of the block's state.
    logic [COUNT_W-1:0] shadow_counts [STORE_DEPTH];
    logic [RSUM_W-1:0]  shadow_rsum [MAX_ROWS];
    logic [TOTAL_W-1:0] shadow_total;
    logic               shadow_dinuc;
    logic [LEN_W-1:0]   shadow_len;

    odds_result_t pending_weights[$];
    int errors;
    int n_items;
    int n_results;
    int n_status [4];
    int stall_left;
    bit calm;   // when set, neither side inserts gaps or stalls

    pwm_log_odds_converter dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAIL pwm_log_odds_converter");
        $finish;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int msb_pos(input longint unsigned v);
        int n;
        n = 0;
        while (v > 1)
        begin
            v >>= 1;
            n++;
        end
        return n;
    endfunction

    // ln(a/b) in Q16 through a Q30 ratio and bitwise log2 by squaring.
    function automatic logic [WEIGHT_W-1:0] ln_ratio_q16(input longint unsigned a,
                                                          input longint unsigned b);
        int la;
        int lb;
        longint e;
        longint unsigned an;
        longint unsigned bn;
        longint unsigned rem;
        longint unsigned q;
        longint unsigned z;
        longint unsigned mag;
        longint unsigned r;
        longint l2;
        longint w;
        la = msb_pos(a);
        lb = msb_pos(b);
        e = la - lb;
        an = a << (61 - la);
        bn = b << (61 - lb);
        if (an < bn)
        begin
            an <<= 1;
            e -= 1;
        end
        q = 1;
        rem = an - bn;
        for (int i = 0; i < 30; i++)
        begin
            rem <<= 1;
            q <<= 1;
            if (rem >= bn)
            begin
                rem -= bn;
                q |= 1;
            end
        end
        z = q;
        l2 = 0;
        for (int i = 0; i < 20; i++)
        begin
            z = (z * z) >> 30;
            l2 <<= 1;
            if (z >= (64'd1 << 31))
            begin
                l2 |= 1;
                z >>= 1;
            end
        end
        l2 += e * 1048576;
        mag = (l2 < 0) ? longint'(-l2) : longint'(l2);
        r = (mag * longint'(LN2_Q32) + (64'd1 << 35)) >> 36;
        if (r > 2097152)
            r = 2097152;
        w = (l2 < 0) ? -longint'(r) : longint'(r);
        if (w > 2097151)
            w = 2097151;
        if (w < -2097152)
            w = -2097152;
        return w[WEIGHT_W-1:0];
    endfunction

    function automatic int rows_in_use();
        return shadow_dinuc ? 16 : 4;
    endfunction

    function automatic int cols_in_use();
        if (shadow_len == 0)
            return 1;
        if (shadow_len > MAX_LENGTH)
            return MAX_LENGTH;
        return shadow_len;
    endfunction

    function automatic void wipe_shadow();
        foreach (shadow_counts[i])
            shadow_counts[i] = '0;
        foreach (shadow_rsum[i])
            shadow_rsum[i] = '0;
        shadow_total = '0;
    endfunction

    // Applies one accepted item to the shadow state and queues any weight it yields.
    function automatic void predict_item(input logic [1:0] op, input int row, input int col,
                                         input int cnt);
        bit fits;
        int idx;
        odds_result_t res;
        longint unsigned size;
        longint unsigned mean;
        longint unsigned a;
        longint unsigned b;
        fits = row < rows_in_use() && col < cols_in_use();
        idx = row * MAX_LENGTH + col;
        if (op == OP_CLEAR)
            wipe_shadow();
        else if (op == OP_WRITE)
        begin
            if (fits)
            begin
                shadow_rsum[row] = shadow_rsum[row] - shadow_counts[idx] + cnt;
                shadow_total = shadow_total - shadow_counts[idx] + cnt;
                shadow_counts[idx] = cnt;
            end
        end
        else if (op == OP_CONVERT)
        begin
            res.weight = '0;
            res.status = ST_OK;
            if (!fits)
                res.status = ST_OUT_RANGE;
            else if (shadow_total == 0)
                res.status = ST_TOTAL_0;
            else
                for (int i = 0; i < rows_in_use(); i++)
                    if (shadow_rsum[i] == 0)
                        res.status = ST_ROW_0;
            if (res.status == ST_OK)
            begin
                size = rows_in_use();
                mean = shadow_total / cols_in_use();
                a = (longint'(shadow_counts[idx]) * size + 1) * shadow_total;
                b = size * (mean + 1) * shadow_rsum[row];
                res.weight = ln_ratio_q16(a, b);
            end
            pending_weights.push_back(res);
        end
    endfunction

    task automatic send_item(input logic [1:0] op, input int row, input int col,
                             input int cnt);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tuser  <= op;
        s_tdata  <= {6'b0, cnt[15:0], col[5:0], row[3:0]};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_item(op, row[3:0], col[5:0], cnt[15:0]);
        n_items++;
    endtask

    // Waits until every weight has come back and any write has settled.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending_weights.size() == 0);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_register(input logic idx, input int value);
        drain();
        cfg_index <= idx;
        cfg_data  <= value[6:0];
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_DINUC)
            shadow_dinuc = value[0];
        else
            shadow_len = value[6:0];
        wipe_shadow();
    endtask

    // Gives every row in use a nonzero count so that converts can reach status ok.
    task automatic fill_rows();
        for (int r = 0; r < rows_in_use(); r++)
            send_item(OP_WRITE, r, $urandom_range(0, cols_in_use() - 1),
                      $urandom_range(1, 65535));
    endtask

    // The receiver may stall for a random number of cycles after each ready cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            m_tready   <= 1'b1;
            stall_left = idle_len();
        end
    end

    always @(posedge clk)
    begin
        odds_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (pending_weights.size() == 0)
                report($sformatf("unexpected result %h", m_tdata));
            else
            begin
                want = pending_weights.pop_front();
                n_status[want.status]++;
                if (m_tdata[21:0] !== want.weight)
                    report($sformatf("weight %h, expected %h", m_tdata[21:0], want.weight));
                if (m_tdata[23:22] !== want.status)
                    report($sformatf("status %0d, expected %0d", m_tdata[23:22],
                                     want.status));
            end
        end
    end

    task automatic test_directed();
        calm = 1'b1;
        send_item(OP_CONVERT, 0, 0, 0);         // empty matrix
        send_item(OP_CONVERT, 4, 0, 0);         // row beyond four
        send_item(OP_CONVERT, 0, 1, 0);         // column beyond length
        send_item(OP_WRITE, 0, 0, 65535);
        send_item(OP_WRITE, 5, 3, 777);         // ignored write
        send_item(OP_CONVERT, 0, 0, 0);         // other rows still zero
        send_item(OP_WRITE, 1, 0, 1);
        send_item(OP_WRITE, 2, 0, 0);
        send_item(OP_WRITE, 3, 0, 65535);
        send_item(OP_WRITE, 2, 0, 2);
        send_item(OP_CONVERT, 0, 0, 0);
        send_item(OP_CONVERT, 1, 0, 0);
        send_item(3, 0, 0, 0);                  // unused code
        send_item(OP_CLEAR, 0, 0, 0);
        send_item(OP_CONVERT, 3, 0, 0);
        calm = 1'b0;
        set_register(CFG_DINUC, 1);
        set_register(CFG_LENGTH, 64);
        for (int r = 0; r < 16; r++)
            send_item(OP_WRITE, r, 63, (r == 15) ? 65535 : r + 1);
        send_item(OP_WRITE, 15, 0, 0);
        send_item(OP_CONVERT, 15, 63, 0);
        send_item(OP_CONVERT, 15, 0, 0);
        send_item(OP_CONVERT, 0, 63, 0);
    endtask

    task automatic test_random_phase(input int dinuc, input int len, input int n);
        int r;
        set_register(CFG_DINUC, dinuc);
        set_register(CFG_LENGTH, len);
        fill_rows();
        calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_item(OP_WRITE, $urandom_range(0, rows_in_use() - 1),
                          $urandom_range(0, cols_in_use() - 1),
                          ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 65535));
            else if (r < 90)
                send_item(OP_CONVERT, $urandom_range(0, rows_in_use() - 1),
                          $urandom_range(0, cols_in_use() - 1), $urandom_range(0, 65535));
            else if (r < 99)
                send_item($urandom_range(0, 3), $urandom_range(0, 15),
                          $urandom_range(0, 63), $urandom_range(0, 65535));
            else
            begin
                send_item(OP_CLEAR, 0, 0, $urandom_range(0, 65535));
                fill_rows();
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_WRITE;
        cfg_valid = 1'b0;
        cfg_index = CFG_DINUC;
        cfg_data  = '0;
        calm      = 1'b0;
        shadow_dinuc = 1'b0;
        shadow_len   = 7'd1;
        wipe_shadow();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_phase(0, 1, 120);
        test_random_phase(1, 64, 160);
        test_random_phase(0, 127, 140);
        test_random_phase(1, 0, 100);
        test_random_phase(0, 37, 150);
        test_random_phase(1, 9, 150);
        drain();
        $display("Sent %0d items over six mode and length settings; %0d weights checked.",
                 n_items, n_results);
        $display("Status counts: ok %0d, empty %0d, zero row %0d, out of range %0d.",
                 n_status[0], n_status[1], n_status[2], n_status[3]);
        if (errors == 0 && pending_weights.size() == 0)
            $display("PASS pwm_log_odds_converter");
        else
            $display("FAIL pwm_log_odds_converter");
        $finish;
    end

endmodule
